/* src/vnacc_pkg.sv */
package vnacc_pkg;

  localparam int unsigned MAX_VERTICES = 4096;
  localparam int unsigned IDX_W        = $clog2(MAX_VERTICES);
  localparam int unsigned COORD_BITS   = 24;
  localparam int unsigned ACC_BITS     = 56;

  // field widths of the transactions
  localparam int unsigned FLD_IDX_W   = 12;
  localparam int unsigned FLD_COORD_W = 24;
  localparam int unsigned NRM_W       = 16;

  // cross product datapath
  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned CRS_W  = PROD_W + 1;

  // normaliser datapath: leading bit lands at MAG_TOP
  localparam int unsigned MAG_TOP = 29;
  localparam int unsigned MAG_W   = MAG_TOP + 1;
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned SUM_W   = SQ_W + 2;
  localparam int unsigned BIT_W   = SUM_W + 1;
  localparam int unsigned LEN_W   = MAG_W + 1;
  localparam int unsigned QUO_W   = NRM_W + 1;
  localparam int unsigned NUM_W   = MAG_W + NRM_W + 1;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_TRI   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]                     func;
    logic [FLD_IDX_W-1:0]           index_a;
    logic [FLD_IDX_W-1:0]           index_b;
    logic [FLD_IDX_W-1:0]           index_c;
    logic signed [FLD_COORD_W-1:0]  coord_x;
    logic signed [FLD_COORD_W-1:0]  coord_y;
    logic signed [FLD_COORD_W-1:0]  coord_z;
  } vnacc_in_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [NRM_W-1:0]  normal_x;
    logic signed [NRM_W-1:0]  normal_y;
    logic signed [NRM_W-1:0]  normal_z;
    logic                     degenerate;
    logic                     saturated;
  } vnacc_out_t;

endpackage

/* src/vnacc_norm.sv */
module vnacc_norm import vnacc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [3*ACC_BITS-1:0]     acc_i,
  output logic                      done_o,
  output logic [3*NRM_W-1:0]        nrm_o
);

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQRT  = 6'b001000,
    N_DIVI  = 6'b010000,
    N_DIV   = 6'b100000
  } nstate_e;

  nstate_e              state_q;
  logic [ACC_BITS-1:0]  mag_q [3];
  logic                 neg_q [3];
  logic [4:0]           cnt_q;
  logic [1:0]           comp_q;
  logic [SQ_W-1:0]      prod_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SUM_W-1:0]     rem_q;
  logic [BIT_W-1:0]     res_q;
  logic [BIT_W-1:0]     bit_q;
  logic [LEN_W-1:0]     len;
  logic [NUM_W-1:0]     num_init;
  logic [QUO_W-1:0]     num_q;
  logic [LEN_W:0]       r_q;
  logic [QUO_W-1:0]     q_q;
  logic [QUO_W-1:0]     q_fin;
  logic [LEN_W+1:0]     div_t;
  logic [LEN_W:0]       div_d;
  logic                 div_ge;
  logic [BIT_W:0]       sq_t;
  logic [ACC_BITS-1:0]  or_mag;
  logic [NRM_W-1:0]     q_clip;
  logic [NRM_W-1:0]     nrm_q [3];
  logic                 done_q;

  assign or_mag   = mag_q[0] | mag_q[1] | mag_q[2];
  assign len      = res_q[LEN_W-1:0];
  assign num_init = {mag_q[comp_q][MAG_W-1:0], {NRM_W{1'b0}}} + NUM_W'(len);
  assign div_d    = {len, 1'b0};
  assign div_t    = {r_q, num_q[QUO_W-1]};
  assign div_ge   = div_t >= (LEN_W+2)'(div_d);
  assign q_fin    = {q_q[QUO_W-2:0], div_ge};
  assign q_clip   = (q_fin > QUO_W'({1'b0, {(NRM_W-1){1'b1}}})) ?
                    {1'b0, {(NRM_W-1){1'b1}}} : q_fin[NRM_W-1:0];
  assign sq_t     = (BIT_W+1)'(res_q) + (BIT_W+1)'(bit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        N_IDLE: begin
          if (start_i) state_q <= N_SHIFT;
        end
        N_SHIFT: begin
          if (!(|or_mag[ACC_BITS-1:MAG_W]) && or_mag[MAG_TOP]) state_q <= N_SQ;
        end
        N_SQ: begin
          if (cnt_q == 5'd3) state_q <= N_SQRT;
        end
        N_SQRT: begin
          if (cnt_q == 5'd31) state_q <= N_DIVI;
        end
        N_DIVI: begin
          state_q <= N_DIV;
        end
        N_DIV: begin
          if (cnt_q == 5'(QUO_W - 1)) begin
            if (comp_q == 2'd2) begin
              state_q <= N_IDLE;
              done_q  <= 1'b1;
            end else begin
              state_q <= N_DIVI;
            end
          end
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        for (int j = 0; j < 3; j++) begin
          neg_q[j] <= acc_i[(2-j)*ACC_BITS + ACC_BITS-1];
          mag_q[j] <= acc_i[(2-j)*ACC_BITS + ACC_BITS-1] ?
                      (~acc_i[(2-j)*ACC_BITS +: ACC_BITS] + 1'b1) :
                      acc_i[(2-j)*ACC_BITS +: ACC_BITS];
        end
        cnt_q  <= '0;
        sum_q  <= '0;
        comp_q <= '0;
      end
      N_SHIFT: begin
        // walk the leading bit to its target, one place a cycle
        for (int j = 0; j < 3; j++) begin
          if (|or_mag[ACC_BITS-1:MAG_W]) mag_q[j] <= mag_q[j] >> 1;
          else if (!or_mag[MAG_TOP])     mag_q[j] <= mag_q[j] << 1;
        end
      end
      N_SQ: begin
        if (cnt_q < 5'd3)
          prod_q <= mag_q[cnt_q[1:0]][MAG_W-1:0] * mag_q[cnt_q[1:0]][MAG_W-1:0];
        if (cnt_q != 5'd0) sum_q <= sum_q + SUM_W'(prod_q);
        if (cnt_q == 5'd3) begin
          rem_q <= sum_q + SUM_W'(prod_q);
          res_q <= '0;
          bit_q <= {1'b1, {(BIT_W-1){1'b0}}};
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + 5'd1;
        end
      end
      N_SQRT: begin
        if ((BIT_W+1)'(rem_q) >= sq_t) begin
          rem_q <= rem_q - sq_t[SUM_W-1:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 5'd1;
      end
      N_DIVI: begin
        r_q   <= (LEN_W+1)'(num_init[NUM_W-1:QUO_W]);
        num_q <= num_init[QUO_W-1:0];
        q_q   <= '0;
        cnt_q <= '0;
      end
      N_DIV: begin
        r_q   <= div_ge ? (div_t[LEN_W:0] - div_d) : div_t[LEN_W:0];
        q_q   <= q_fin;
        num_q <= num_q << 1;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(QUO_W - 1)) begin
          nrm_q[comp_q] <= neg_q[comp_q] ? (~q_clip + 1'b1) : q_clip;
          comp_q        <= comp_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign nrm_o  = {nrm_q[0], nrm_q[1], nrm_q[2]};

endmodule

/* src/vertex_normal_accumulator.sv */
// Vertex normal engine: one transaction in, one result out.
// A write stores one vertex; a triangle does vertex reads, six products on
// one multiplier and three accumulator read-modify-writes; a read shifts one
// place a cycle, then runs a 32-step square root and three 17-step divisions.
// A zero-sum read bypasses the normaliser; unknown or out-of-range ones go straight to the result.
// After reset a clearing pass zeroes all 4096 accumulator entries.
module vertex_normal_accumulator import vnacc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  vnacc_in_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output vnacc_out_t  out_data_o
);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_WRITE = 12'b000000000100,
    S_VRD   = 12'b000000001000,
    S_DIFF  = 12'b000000010000,
    S_MUL   = 12'b000000100000,
    S_ARD   = 12'b000001000000,
    S_AWR   = 12'b000010000000,
    S_RRD   = 12'b000100000000,
    S_RCHK  = 12'b001000000000,
    S_NORM  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  state_e                    state_q;
  vnacc_in_t                 item_q;
  logic [IDX_W-1:0]          clr_q;
  logic [2:0]                cnt_q;
  logic [1:0]                corner_q;
  logic                      sat_q;
  logic                      deg_q;
  logic [3*NRM_W-1:0]        nrm_q;
  logic                      out_valid_q;
  vnacc_out_t                out_q;

  logic [3*COORD_BITS-1:0]   vmem [MAX_VERTICES];
  logic [3*ACC_BITS-1:0]     amem [MAX_VERTICES];
  logic [3*COORD_BITS-1:0]   vrd_q;
  logic [3*ACC_BITS-1:0]     ard_q;
  logic [IDX_W-1:0]          vaddr;
  logic [IDX_W-1:0]          aaddr;
  logic [IDX_W-1:0]          corner_idx;
  logic                      a_we;
  logic [3*ACC_BITS-1:0]     a_wdata;
  logic [3*ACC_BITS-1:0]     a_upd;
  logic                      clip;

  logic signed [COORD_BITS-1:0] va_q [3];
  logic signed [COORD_BITS-1:0] vb_q [3];
  logic signed [COORD_BITS-1:0] vc_q [3];
  logic signed [DIFF_W-1:0]     u_q  [3];
  logic signed [DIFF_W-1:0]     v_q  [3];
  logic signed [DIFF_W-1:0]     op_a;
  logic signed [DIFF_W-1:0]     op_b;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [CRS_W-1:0]      n_q  [3];

  logic                      accept;
  logic                      out_free;
  logic                      ia_ok, ib_ok, ic_ok;
  logic                      norm_start;
  logic                      norm_done;
  logic [3*NRM_W-1:0]        norm_nrm;

  function automatic logic [ACC_BITS:0] sat_add(logic [ACC_BITS-1:0] a,
                                                logic signed [CRS_W-1:0] b);
    logic [ACC_BITS:0] s;
    logic [ACC_BITS:0] r;
    s = {a[ACC_BITS-1], a} + (ACC_BITS+1)'(b);
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      r = s[ACC_BITS] ? {1'b1, 1'b1, {(ACC_BITS-1){1'b0}}}
                      : {1'b1, 1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      r = {1'b0, s[ACC_BITS-1:0]};
    end
    return r;
  endfunction

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign ia_ok    = 32'(in_data_i.index_a) < MAX_VERTICES;
  assign ib_ok    = 32'(in_data_i.index_b) < MAX_VERTICES;
  assign ic_ok    = 32'(in_data_i.index_c) < MAX_VERTICES;

  always_comb begin
    case (corner_q)
      2'd0:    corner_idx = item_q.index_a[IDX_W-1:0];
      2'd1:    corner_idx = item_q.index_b[IDX_W-1:0];
      default: corner_idx = item_q.index_c[IDX_W-1:0];
    endcase
  end

  always_comb begin
    if (state_q == S_VRD) begin
      case (cnt_q)
        3'd0:    vaddr = item_q.index_a[IDX_W-1:0];
        3'd1:    vaddr = item_q.index_b[IDX_W-1:0];
        default: vaddr = item_q.index_c[IDX_W-1:0];
      endcase
    end else begin
      vaddr = item_q.index_a[IDX_W-1:0];
    end
  end

  always_comb begin
    case (state_q)
      S_CLEAR:      aaddr = clr_q;
      S_ARD, S_AWR: aaddr = corner_idx;
      default:      aaddr = item_q.index_a[IDX_W-1:0];
    endcase
  end

  always_comb begin
    logic [ACC_BITS:0] s;
    clip  = 1'b0;
    a_upd = '0;
    for (int j = 0; j < 3; j++) begin
      s = sat_add(ard_q[(2-j)*ACC_BITS +: ACC_BITS], n_q[j]);
      a_upd[(2-j)*ACC_BITS +: ACC_BITS] = s[ACC_BITS-1:0];
      clip = clip | s[ACC_BITS];
    end
  end

  assign a_we    = (state_q == S_CLEAR) || (state_q == S_WRITE) || (state_q == S_AWR);
  assign a_wdata = (state_q == S_AWR) ? a_upd : '0;

  // memories
  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE)
      vmem[vaddr] <= {item_q.coord_x[COORD_BITS-1:0], item_q.coord_y[COORD_BITS-1:0],
                      item_q.coord_z[COORD_BITS-1:0]};
    vrd_q <= vmem[vaddr];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) amem[aaddr] <= a_wdata;
    ard_q <= amem[aaddr];
  end

  always_comb begin
    case (cnt_q)
      3'd0:    begin op_a = u_q[1]; op_b = v_q[2]; end
      3'd1:    begin op_a = u_q[2]; op_b = v_q[1]; end
      3'd2:    begin op_a = u_q[2]; op_b = v_q[0]; end
      3'd3:    begin op_a = u_q[0]; op_b = v_q[2]; end
      3'd4:    begin op_a = u_q[0]; op_b = v_q[1]; end
      default: begin op_a = u_q[1]; op_b = v_q[0]; end
    endcase
  end

  assign norm_start = (state_q == S_RCHK) && (ard_q != '0);

  vnacc_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .acc_i   (ard_q),
    .done_o  (norm_done),
    .nrm_o   (norm_nrm)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IDX_W'(MAX_VERTICES - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (in_data_i.func)
              FUNC_WRITE: state_q <= ia_ok ? S_WRITE : S_DONE;
              FUNC_TRI:   state_q <= (ia_ok && ib_ok && ic_ok) ? S_VRD : S_DONE;
              FUNC_READ:  state_q <= ia_ok ? S_RRD : S_DONE;
              default:    state_q <= S_DONE;
            endcase
          end
        end
        S_WRITE: state_q <= S_DONE;
        S_VRD:   if (cnt_q == 3'd3) state_q <= S_DIFF;
        S_DIFF:  state_q <= S_MUL;
        S_MUL:   if (cnt_q == 3'd6) state_q <= S_ARD;
        S_ARD:   state_q <= S_AWR;
        S_AWR:   state_q <= (corner_q == 2'd2) ? S_DONE : S_ARD;
        S_RRD:   state_q <= S_RCHK;
        S_RCHK:  state_q <= (ard_q == '0) ? S_DONE : S_NORM;
        S_NORM:  if (norm_done) state_q <= S_DONE;
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_q   <= in_data_i;
          sat_q    <= 1'b0;
          deg_q    <= (in_data_i.func == FUNC_READ) && !ia_ok;
          nrm_q    <= '0;
          cnt_q    <= '0;
          corner_q <= '0;
        end
      end
      S_VRD: begin
        for (int j = 0; j < 3; j++) begin
          case (cnt_q)
            3'd1:    va_q[j] <= vrd_q[(2-j)*COORD_BITS +: COORD_BITS];
            3'd2:    vb_q[j] <= vrd_q[(2-j)*COORD_BITS +: COORD_BITS];
            3'd3:    vc_q[j] <= vrd_q[(2-j)*COORD_BITS +: COORD_BITS];
            default: ;
          endcase
        end
        cnt_q <= (cnt_q == 3'd3) ? 3'd0 : cnt_q + 3'd1;
      end
      S_DIFF: begin
        for (int j = 0; j < 3; j++) begin
          u_q[j] <= DIFF_W'(va_q[j]) - DIFF_W'(vb_q[j]);
          v_q[j] <= DIFF_W'(vc_q[j]) - DIFF_W'(vb_q[j]);
        end
      end
      S_MUL: begin
        // product of step k is registered and taken in at step k+1; even steps load, odd subtract
        if (cnt_q != 3'd6) prod_q <= op_a * op_b;
        case (cnt_q)
          3'd1: n_q[0] <= CRS_W'(prod_q);
          3'd2: n_q[0] <= n_q[0] - CRS_W'(prod_q);
          3'd3: n_q[1] <= CRS_W'(prod_q);
          3'd4: n_q[1] <= n_q[1] - CRS_W'(prod_q);
          3'd5: n_q[2] <= CRS_W'(prod_q);
          3'd6: n_q[2] <= n_q[2] - CRS_W'(prod_q);
          default: ;
        endcase
        cnt_q <= cnt_q + 3'd1;
      end
      S_AWR: begin
        sat_q    <= sat_q | clip;
        corner_q <= corner_q + 2'd1;
      end
      S_RCHK: begin
        if (ard_q == '0) deg_q <= 1'b1;
      end
      S_NORM: begin
        if (norm_done) nrm_q <= norm_nrm;
      end
      S_DONE: begin
        if (out_free) begin
          out_q.kind       <= item_q.func;
          out_q.normal_x   <= nrm_q[2*NRM_W +: NRM_W];
          out_q.normal_y   <= nrm_q[NRM_W +: NRM_W];
          out_q.normal_z   <= nrm_q[0 +: NRM_W];
          out_q.degenerate <= deg_q;
          out_q.saturated  <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
